>>> sv/ssm_pkg.sv
// Shared types and constants for the Shift-And string matcher.
`timescale 1ns / 1ps
package ssm_pkg;

	localparam int CMD_W = 2;
	localparam int CHAR_W = 7;
	localparam int PATTERN_MAX_DEF = 64;
	localparam int ALPHABET_SIZE_DEF = 128;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TEXT = 2'd2;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_APPEND,
		OP_TEXT,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t op;
		logic [CHAR_W-1:0] ch;
		logic in_alpha;
	} q_item_t;

endpackage

>>> sv/ssm_front.sv
// Input stage: takes stream transfers and classifies each command.
`timescale 1ns / 1ps
module ssm_front import ssm_pkg::*; #(
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [CMD_W-1:0] s_cmd,
	input  logic [CHAR_W-1:0] s_char,
	output logic q_valid,
	input  logic q_ready,
	output q_item_t q_item
);

	logic v_q;
	q_item_t item_q;
	op_t op_dec;

	always_comb begin
		unique case (s_cmd)
			CMD_CLEAR:  op_dec = OP_CLEAR;
			CMD_APPEND: op_dec = OP_APPEND;
			CMD_TEXT:   op_dec = OP_TEXT;
			default:    op_dec = OP_NOP;
		endcase
	end

	assign s_tready = !v_q || q_ready;
	assign q_valid = v_q;
	assign q_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_q <= 1'b1;
		end else if (q_ready) begin
			v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_q.op <= op_dec;
			item_q.ch <= s_char;
			item_q.in_alpha <= (int'(s_char) < ALPHABET_SIZE);
		end
	end

endmodule

>>> sv/ssm_queue.sv
// Small FIFO that decouples the input stage from the matching engine.
`timescale 1ns / 1ps
module ssm_queue import ssm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  q_item_t push_item,
	output logic pop_valid,
	input  logic pop_ready,
	output q_item_t pop_item
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	q_item_t slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic push;
	logic pop;

	assign push_ready = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_item = slots_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> sv/ssm_back.sv
// Matching engine: mask table, pattern length, active vector and result register.
`timescale 1ns / 1ps
module ssm_back import ssm_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_ready,
	input  q_item_t q_item,
	output logic m_valid,
	input  logic m_ready,
	output logic m_match,
	output logic m_overflow
);

	localparam int PW = PATTERN_MAX;
	localparam int LW = $clog2(PATTERN_MAX + 1);
	localparam int AW = $clog2(ALPHABET_SIZE);

	logic [PW-1:0] mask_mem [ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0] valid_q;

	logic s1_valid;
	op_t op_s1;
	logic [AW-1:0] addr_s1;
	logic in_alpha_s1;
	logic [PW-1:0] mask_s1;
	logic ent_valid_s1;

	logic [PW-1:0] active_q;
	logic [LW-1:0] len_q;
	logic out_valid_q;
	logic match_q;
	logic ovf_q;

	logic adv;
	logic pop;
	logic [AW-1:0] hd_addr;
	logic [PW-1:0] mask_eff;
	logic full;
	logic [PW-1:0] act_next;
	logic [PW-1:0] tap;
	logic [PW-1:0] set_vec;
	logic wr_en;
	logic clr;
	logic [PW-1:0] wr_data;
	logic res_match;
	logic res_ovf;

	assign adv = s1_valid && (!out_valid_q || m_ready);
	assign pop = !s1_valid || adv;
	assign q_ready = pop;
	assign hd_addr = AW'(q_item.ch);

	assign mask_eff = (ent_valid_s1 && in_alpha_s1) ? mask_s1 : '0;
	assign full = (len_q >= LW'(PATTERN_MAX));
	assign act_next = ((active_q << 1) | PW'(1)) & mask_eff;
	assign tap = PW'(1) << (len_q - LW'(1));
	assign set_vec = PW'(1) << len_q;
	assign wr_data = mask_eff | set_vec;

	always_comb begin
		wr_en = 1'b0;
		clr = 1'b0;
		res_match = 1'b0;
		res_ovf = 1'b0;
		unique case (op_s1)
			OP_CLEAR: begin
				clr = adv;
			end
			OP_APPEND: begin
				res_ovf = full;
				wr_en = adv && !full && in_alpha_s1;
			end
			OP_TEXT: begin
				res_match = (len_q != '0) && (|(act_next & tap));
			end
			default: begin
			end
		endcase
	end

	// Table read for the queue head; a write from the item ahead is bypassed.
	always_ff @(posedge clk) begin
		if (pop && q_valid) begin
			op_s1 <= q_item.op;
			addr_s1 <= hd_addr;
			in_alpha_s1 <= q_item.in_alpha;
			mask_s1 <= (wr_en && (addr_s1 == hd_addr)) ? wr_data : mask_mem[hd_addr];
		end
		if (wr_en) begin
			mask_mem[addr_s1] <= wr_data;
		end
		if (adv) begin
			match_q <= res_match;
			ovf_q <= res_ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			ent_valid_s1 <= 1'b0;
			valid_q <= '0;
			active_q <= '0;
			len_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				s1_valid <= q_valid;
			end
			if (pop && q_valid) begin
				if (clr) begin
					ent_valid_s1 <= 1'b0;
				end else if (wr_en && (addr_s1 == hd_addr)) begin
					ent_valid_s1 <= 1'b1;
				end else begin
					ent_valid_s1 <= valid_q[hd_addr];
				end
			end
			if (clr) begin
				valid_q <= '0;
				active_q <= '0;
				len_q <= '0;
			end else if (adv && (op_s1 == OP_APPEND) && !full) begin
				len_q <= len_q + LW'(1);
				if (wr_en) begin
					valid_q[addr_s1] <= 1'b1;
				end
			end else if (adv && (op_s1 == OP_TEXT)) begin
				active_q <= act_next;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_valid = out_valid_q;
	assign m_match = match_q;
	assign m_overflow = ovf_q;

endmodule

>>> sv/shift_and_string_matcher_top.sv
// Top level of the Shift-And exact string matcher.
`timescale 1ns / 1ps
// Commands arrive on the slave stream: tuser selects clear, pattern append or text, and tdata
// carries the character. Each transfer yields exactly one result transfer with match and
// overflow flags. The block sustains one transfer per cycle while the output accepts results; a
// transfer passes through the input register, the queue, the table read stage and the result
// register. The rate is set by the mask table, which is read and written once per cycle with
// a bypass between consecutive items. While the output stalls, the input keeps taking
// transfers until seven items are held: one in the input register, four in the queue, one in
// the table read stage and one in the result register.
module shift_and_string_matcher_top import ssm_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,  // [6:0] char_code, [7] zero
	input  logic [1:0] s_tuser,  // [1:0] cmd
	output logic m_tvalid,
	input  logic m_tready,
	output logic [7:0] m_tdata   // [0] match, [1] overflow, [7:2] zero
);

	logic fr_valid;
	logic q_ready;
	q_item_t fr_item;
	logic hd_valid;
	logic hd_ready;
	q_item_t hd_item;
	logic res_match;
	logic res_ovf;

	ssm_front #(
		.ALPHABET_SIZE(ALPHABET_SIZE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_cmd(s_tuser),
		.s_char(s_tdata[CHAR_W-1:0]),
		.q_valid(fr_valid),
		.q_ready(q_ready),
		.q_item(fr_item)
	);

	ssm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(fr_valid),
		.push_ready(q_ready),
		.push_item(fr_item),
		.pop_valid(hd_valid),
		.pop_ready(hd_ready),
		.pop_item(hd_item)
	);

	ssm_back #(
		.PATTERN_MAX(PATTERN_MAX),
		.ALPHABET_SIZE(ALPHABET_SIZE)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(hd_valid),
		.q_ready(hd_ready),
		.q_item(hd_item),
		.m_valid(m_tvalid),
		.m_ready(m_tready),
		.m_match(res_match),
		.m_overflow(res_ovf)
	);

	assign m_tdata = {6'd0, res_ovf, res_match};

	// A result never reports a match and an overflow together.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("match and overflow raised together");

	// Input backpressure only comes from a held input register and a full queue.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (fr_valid && !q_ready))
		else $error("input stalled without a full queue");

	// A stalled result stays in place with its flags unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");

endmodule
